// File: sv/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

	// job queue between parser and emitter
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// result kinds on the output stream
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_CONTROL   = 4'd1;
	localparam logic [3:0] ERR_TRUNC_ESC = 4'd2;
	localparam logic [3:0] ERR_UNK_ESC   = 4'd3;
	localparam logic [3:0] ERR_TRUNC_HEX = 4'd4;
	localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
	localparam logic [3:0] ERR_NO_LOW    = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
	localparam logic [3:0] ERR_LONE_LOW  = 4'd8;
	localparam logic [3:0] ERR_UNTERM    = 4'd9;
	localparam logic [3:0] ERR_UTF8      = 4'd10;

	// characters
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// what the back end has to do with one job
	typedef enum logic [1:0] {
		JOB_BYTE   = 2'd0, // one raw byte, data[7:0]
		JOB_SCALAR = 2'd1, // code point, data[20:0], UTF-8 encoded
		JOB_QUOTE  = 2'd2, // closing quote, verdict from UTF-8 check
		JOB_ERR    = 2'd3  // parse error, code in data[3:0]
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [20:0] data;
	} job_t;

	typedef struct packed {
		logic [31:0] bytes; // first byte in the lowest bits
		logic [2:0]  len;
	} utf8_enc_t;

	// hex digit: bit 4 set when valid
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// single-character escape: bit 8 set when known
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h22: r = {1'b1, 8'h22};
			8'h5c: r = {1'b1, 8'h5c};
			8'h2f: r = {1'b1, 8'h2f};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0c};
			8'h6e: r = {1'b1, 8'h0a};
			8'h72: r = {1'b1, 8'h0d};
			8'h74: r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// code point to 1..4 UTF-8 bytes
	function automatic utf8_enc_t utf8_encode(input logic [20:0] s);
		utf8_enc_t r;
		r.bytes = 32'd0;
		r.len   = 3'd0;
		if (s <= 21'h7f) begin
			r.bytes = {24'd0, 1'b0, s[6:0]};
			r.len   = 3'd1;
		end else if (s <= 21'h7ff) begin
			r.bytes = {16'd0, 2'b10, s[5:0], 3'b110, s[10:6]};
			r.len   = 3'd2;
		end else if (s <= 21'hffff) begin
			r.bytes = {8'd0, 2'b10, s[5:0], 2'b10, s[11:6], 4'b1110, s[15:12]};
			r.len   = 3'd3;
		end else begin
			r.bytes = {2'b10, s[5:0], 2'b10, s[11:6], 2'b10, s[17:12], 5'b11110, s[20:18]};
			r.len   = 3'd4;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/jsu_front.sv
`default_nettype none
module jsu_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [7:0]       in_byte,
	input  wire              input_end,
	input  wire              q_full,
	output logic             push,
	output jsu_pkg::job_t    push_job
);

	typedef enum logic [6:0] {
		PH_BODY = 7'b0000001,
		PH_ESC  = 7'b0000010,
		PH_HEX1 = 7'b0000100,
		PH_BSL  = 7'b0001000,
		PH_U    = 7'b0010000,
		PH_HEX2 = 7'b0100000,
		PH_IDLE = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [11:0] acc_q, acc_d;
	logic [1:0]  dig_q, dig_d;
	logic [9:0]  high_q, high_d;
	logic        take;
	logic [4:0]  hx;
	logic [8:0]  esc;
	logic [15:0] quad;
	logic        quad_high, quad_low;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign hx       = jsu_pkg::hex_val(in_byte);
	assign esc      = jsu_pkg::esc_map(in_byte);
	assign quad      = {acc_q, hx[3:0]};
	assign quad_high = quad[15:10] == 6'b110110;
	assign quad_low  = quad[15:10] == 6'b110111;

	// parse one byte, at most one job out
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		dig_d    = dig_q;
		high_d   = high_q;
		push     = 1'b0;
		push_job = '{kind: jsu_pkg::JOB_ERR, data: 21'd0};
		if (take) begin
			if (phase_q == PH_IDLE) begin
				if (!input_end && in_byte == jsu_pkg::CH_QUOTE) begin
					phase_d = PH_BODY;
					acc_d   = 12'd0;
					dig_d   = 2'd0;
					high_d  = 10'd0;
				end
			end else if (input_end) begin
				push          = 1'b1;
				phase_d       = PH_IDLE;
				push_job.kind = jsu_pkg::JOB_ERR;
				case (phase_q)
					PH_ESC:          push_job.data = {17'd0, jsu_pkg::ERR_TRUNC_ESC};
					PH_HEX1, PH_HEX2: push_job.data = {17'd0, jsu_pkg::ERR_TRUNC_HEX};
					PH_BSL, PH_U:    push_job.data = {17'd0, jsu_pkg::ERR_NO_LOW};
					default:         push_job.data = {17'd0, jsu_pkg::ERR_UNTERM};
				endcase
			end else begin
				case (phase_q)
					PH_BODY: begin
						push = 1'b1;
						if (in_byte == jsu_pkg::CH_QUOTE) begin
							push_job.kind = jsu_pkg::JOB_QUOTE;
							phase_d       = PH_IDLE;
						end else if (in_byte < jsu_pkg::CH_SPACE) begin
							push_job.data = {17'd0, jsu_pkg::ERR_CONTROL};
							phase_d       = PH_IDLE;
						end else if (in_byte == jsu_pkg::CH_BSL) begin
							push    = 1'b0;
							phase_d = PH_ESC;
						end else begin
							push_job.kind = jsu_pkg::JOB_BYTE;
							push_job.data = {13'd0, in_byte};
						end
					end
					PH_ESC: begin
						if (in_byte == jsu_pkg::CH_U) begin
							phase_d = PH_HEX1;
							acc_d   = 12'd0;
							dig_d   = 2'd0;
						end else if (esc[8]) begin
							push          = 1'b1;
							push_job.kind = jsu_pkg::JOB_BYTE;
							push_job.data = {13'd0, esc[7:0]};
							phase_d       = PH_BODY;
						end else begin
							push          = 1'b1;
							push_job.data = {17'd0, jsu_pkg::ERR_UNK_ESC};
							phase_d       = PH_IDLE;
						end
					end
					PH_BSL: begin
						if (in_byte == jsu_pkg::CH_BSL) begin
							phase_d = PH_U;
						end else begin
							push          = 1'b1;
							push_job.data = {17'd0, jsu_pkg::ERR_NO_LOW};
							phase_d       = PH_IDLE;
						end
					end
					PH_U: begin
						if (in_byte == jsu_pkg::CH_U) begin
							phase_d = PH_HEX2;
							acc_d   = 12'd0;
							dig_d   = 2'd0;
						end else begin
							push          = 1'b1;
							push_job.data = {17'd0, jsu_pkg::ERR_NO_LOW};
							phase_d       = PH_IDLE;
						end
					end
					PH_HEX1, PH_HEX2: begin
						if (!hx[4]) begin
							push          = 1'b1;
							push_job.data = {17'd0, jsu_pkg::ERR_BAD_HEX};
							phase_d       = PH_IDLE;
						end else if (dig_q != 2'd3) begin
							acc_d = quad[11:0];
							dig_d = dig_q + 2'd1;
						end else begin
							acc_d = 12'd0;
							dig_d = 2'd0;
							if (phase_q == PH_HEX1) begin
								if (quad_high) begin
									high_d  = quad[9:0];
									phase_d = PH_BSL;
								end else if (quad_low) begin
									push          = 1'b1;
									push_job.data = {17'd0, jsu_pkg::ERR_LONE_LOW};
									phase_d       = PH_IDLE;
								end else begin
									push          = 1'b1;
									push_job.kind = jsu_pkg::JOB_SCALAR;
									push_job.data = {5'd0, quad};
									phase_d       = PH_BODY;
								end
							end else if (!quad_low) begin
								push          = 1'b1;
								push_job.data = {17'd0, jsu_pkg::ERR_BAD_LOW};
								phase_d       = PH_IDLE;
							end else begin
								// join the surrogate pair
								push          = 1'b1;
								push_job.kind = jsu_pkg::JOB_SCALAR;
								push_job.data = 21'h10000 + {1'b0, high_q, quad[9:0]};
								high_d        = 10'd0;
								phase_d       = PH_BODY;
							end
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BODY;
			acc_q   <= 12'd0;
			dig_q   <= 2'd0;
			high_q  <= 10'd0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			dig_q   <= dig_d;
			high_q  <= high_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/jsu_queue.sv
`default_nettype none
module jsu_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  jsu_pkg::job_t  push_job,
	output logic           full,
	input  wire            pop,
	output logic           avail,
	output jsu_pkg::job_t  head
);

	jsu_pkg::job_t                  mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [jsu_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_pop;

	assign full   = cnt_q == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH);
	assign avail  = cnt_q != '0;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && avail;

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/jsu_back.sv
`default_nettype none
module jsu_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_avail,
	input  jsu_pkg::job_t  q_head,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_ready,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic [3:0]     error_code,
	output logic           last_of_run
);

	// job being emitted
	logic [31:0]        buf_q;
	logic [2:0]         cnt_q;
	jsu_pkg::job_kind_t jkind_q;
	logic [3:0]         ecode_q;

	// UTF-8 checker state
	logic [1:0] pend_q, pend_d;
	logic [1:0] lim_q, lim_d;
	logic       inv_q, inv_d;

	// output register
	logic       ov_q;
	logic [1:0] okind_q;
	logic [7:0] obyte_q;
	logic [3:0] ocode_q;
	logic       olast_q;

	logic              can_emit, emit;
	logic [7:0]        b, bound;
	logic              ok;
	jsu_pkg::utf8_enc_t enc;

	assign can_emit = !ov_q || out_ready;
	assign emit     = (cnt_q != 3'd0) && can_emit;
	assign pop      = q_avail && ((cnt_q == 3'd0) || (cnt_q == 3'd1 && emit));
	assign enc      = jsu_pkg::utf8_encode(q_head.data);
	assign b        = buf_q[7:0];

	// strict UTF-8 check of the byte going out
	always_comb begin
		pend_d = pend_q;
		lim_d  = lim_q;
		inv_d  = inv_q;
		bound  = (pend_q == 2'd3) ? 8'h90 : 8'ha0;
		ok     = 1'b1;
		if (emit) begin
			if (jkind_q == jsu_pkg::JOB_QUOTE || jkind_q == jsu_pkg::JOB_ERR) begin
				// string over, start clean
				pend_d = 2'd0;
				lim_d  = 2'd0;
				inv_d  = 1'b0;
			end else if (!inv_q) begin
				if (pend_q != 2'd0) begin
					ok = b[7:6] == 2'b10;
					if (lim_q == 2'd1 && b < bound) begin
						ok = 1'b0;
					end
					if (lim_q == 2'd2 && b >= bound) begin
						ok = 1'b0;
					end
					if (!ok) begin
						inv_d = 1'b1;
					end else begin
						lim_d  = 2'd0;
						pend_d = pend_q - 2'd1;
					end
				end else if (b <= 8'h7f) begin
					pend_d = 2'd0;
				end else if (b >= 8'hc2 && b <= 8'hdf) begin
					pend_d = 2'd1;
				end else if (b >= 8'he0 && b <= 8'hef) begin
					pend_d = 2'd2;
					lim_d  = (b == 8'he0) ? 2'd1 : (b == 8'hed) ? 2'd2 : 2'd0;
				end else if (b >= 8'hf0 && b <= 8'hf4) begin
					pend_d = 2'd3;
					lim_d  = (b == 8'hf0) ? 2'd1 : (b == 8'hf4) ? 2'd2 : 2'd0;
				end else begin
					inv_d = 1'b1;
				end
			end
		end
	end

	// job expansion: load on pop, shift one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 3'd0;
			jkind_q <= jsu_pkg::JOB_BYTE;
			pend_q  <= 2'd0;
			lim_q   <= 2'd0;
			inv_q   <= 1'b0;
		end else begin
			pend_q <= pend_d;
			lim_q  <= lim_d;
			inv_q  <= inv_d;
			if (pop) begin
				jkind_q <= q_head.kind;
				case (q_head.kind)
					jsu_pkg::JOB_SCALAR: cnt_q <= enc.len;
					default:             cnt_q <= 3'd1;
				endcase
			end else if (emit) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ecode_q <= q_head.data[3:0];
			case (q_head.kind)
				jsu_pkg::JOB_SCALAR: buf_q <= enc.bytes;
				default:             buf_q <= {24'd0, q_head.data[7:0]};
			endcase
		end else if (emit) begin
			buf_q <= {8'd0, buf_q[31:8]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			olast_q <= cnt_q == 3'd1;
			case (jkind_q)
				jsu_pkg::JOB_QUOTE: begin
					obyte_q <= 8'd0;
					if (inv_q || pend_q != 2'd0) begin
						okind_q <= jsu_pkg::KIND_ERR;
						ocode_q <= jsu_pkg::ERR_UTF8;
					end else begin
						okind_q <= jsu_pkg::KIND_DONE;
						ocode_q <= jsu_pkg::ERR_NONE;
					end
				end
				jsu_pkg::JOB_ERR: begin
					okind_q <= jsu_pkg::KIND_ERR;
					obyte_q <= 8'd0;
					ocode_q <= ecode_q;
				end
				default: begin
					okind_q <= jsu_pkg::KIND_BYTE;
					obyte_q <= b;
					ocode_q <= jsu_pkg::ERR_NONE;
				end
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign out_kind    = okind_q;
	assign out_byte    = obyte_q;
	assign error_code  = ocode_q;
	assign last_of_run = olast_q;

endmodule
`default_nettype wire

// File: sv/json_string_unescape_utf8_unit.sv
// JSON string-body unescaper with strict UTF-8 checking. Feed the bytes after
// the opening quote, one per transfer (s_tuser[0] set marks end of input). Raw
// bytes pass through, escapes and \uXXXX (with surrogate pairs) come out as
// 1..4 UTF-8 bytes, one result per cycle while m_tready is high; the closing
// quote gives done or error 10, any error gives one error result, and the unit
// then ignores input until the next quote. The front parser takes one byte per
// cycle while its 4-job queue has room; the emitter drains one output byte per
// cycle unless m_tready holds it. An accepted byte's first result passes the
// job queue, the emitter's job buffer and the output register to m_tvalid.
// m_tlast marks the final result caused by one input byte.
`default_nettype none
module json_string_unescape_utf8_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [7:0] in_byte
	input  wire  [0:0]  s_tuser,  // [0] input_end
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_byte, [11:8] error_code, rest zero
	output logic [1:0]  m_tuser,  // [1:0] out_kind
	output logic        m_tlast
);

	jsu_pkg::job_t push_job, head;
	logic          push, full, avail, pop;
	logic [7:0]    out_byte;
	logic [3:0]    error_code;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.input_end (s_tuser[0]),
		.q_full    (full),
		.push      (push),
		.push_job  (push_job)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_avail     (avail),
		.q_head      (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_byte    (out_byte),
		.error_code  (error_code),
		.last_of_run (m_tlast)
	);

	assign m_tdata = {4'd0, error_code, out_byte};

endmodule
`default_nettype wire
